/* hw/rtl/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TRYI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define TRYI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TRYI_ASSERT(lbl, clk, rst, prop)
`define TRYI_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hw/rtl/tryi_pkg.sv */
package tryi_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CK,
    S_RD0,
    S_RD0_CK,
    S_FRAC_DIV,
    S_FRAC_WAIT,
    S_VMUL,
    S_VFIX,
    S_LOG_INIT,
    S_LOG_NORM,
    S_LOG_SQ,
    S_LOG_ADJ,
    S_BL_MUL,
    S_BL_DIV,
    S_BL_WAIT,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    CFG_LOWER_COUNT,
    CFG_UPPER_COUNT,
    CFG_LOWER_Z,
    CFG_UPPER_Z,
    CFG_SINGLE
  } cfg_index_t;

  typedef enum logic [1:0] {
    LOG_LOWER,
    LOG_UPPER,
    LOG_QUERY
  } log_sel_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZDEN = 2'd2;

  localparam logic signed [63:0] FRAC_LO   = -64'sd26214;
  localparam logic signed [63:0] FRAC_HI   = 64'sd91750;
  localparam logic signed [63:0] INT32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] INT32_MIN = -64'sd2147483648;

  localparam int DIV_W = 64;

endpackage

/* hw/rtl/tryi_req_if.sv */
interface tryi_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic               ridge_sel;
  logic [3:0]         point_index;
  logic [15:0]        mass;
  logic signed [31:0] yield_value;
  logic [23:0]        metallicity;

  modport source (output valid, req_type, ridge_sel, point_index, mass, yield_value,
                  metallicity, input ready);
  modport sink (input valid, req_type, ridge_sel, point_index, mass, yield_value,
                metallicity, output ready);
endinterface

/* hw/rtl/tryi_rsp_if.sv */
interface tryi_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interpolated_yield;
  logic [1:0]         status;

  modport source (output valid, interpolated_yield, status, input ready);
  modport sink (input valid, interpolated_yield, status, output ready);
endinterface

/* hw/rtl/tryi_ram.sv */
module tryi_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/tryi_div.sv */
module tryi_div
  import tryi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] dividend,
  input  logic signed [DIV_W-1:0] divisor,
  output logic                    done,
  output logic signed [DIV_W-1:0] quotient
);
  localparam int CW = $clog2(DIV_W) + 1;

  logic             busy;
  logic [CW-1:0]    cnt;
  logic             neg;
  logic [DIV_W-1:0] dmag;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W:0]   sh;
  logic             take;

  assign sh   = {rem, quo[DIV_W-1]};
  assign take = sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[DIV_W-1] ^ divisor[DIV_W-1];
      quo  <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
      dmag <= divisor[DIV_W-1] ? DIV_W'(-divisor) : DIV_W'(divisor);
      rem  <= '0;
    end else if (busy) begin
      rem <= take ? DIV_W'(sh - {1'b0, dmag}) : sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], take};
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);
endmodule

/* hw/rtl/two_ridge_yield_interpolator_top.sv */
// Two-ridge yield interpolator. A load transaction writes one (mass, yield) point into
// the lower or upper ridge table; it produces no result. A query transaction searches
// the mass bracket in the lower table, and in the upper table too unless in
// single-ridge mode, with a read state and a check state per search step. It
// interpolates using the shared bit-serial divider and the shared multiplier;
// in two-ridge mode it then takes three base-2 logarithms (a normalize loop and
// a squaring loop each, on the same multiplier) and blends with one more division.
// Query time is set mainly by the bit-serial divider and the log squaring loop; a
// zero mass or log denominator skips its division. The result may wait while the
// output is held off. The block takes no new transaction while a query is in
// progress. Table contents are not cleared at reset.
`include "assert_macros.svh"
module two_ridge_yield_interpolator_top
  import tryi_pkg::*;
#(
  parameter int POINTS_MAX = 16
) (
  input  logic              clk,
  input  logic              rst,
  tryi_req_if.sink          req,
  tryi_rsp_if.source        rsp,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data
);
  localparam int AW = (POINTS_MAX > 1) ? $clog2(POINTS_MAX) : 1;
  localparam int NW = $clog2(POINTS_MAX + 1) + 5;

  state_t state, state_next;

  logic [4:0]  lower_count, upper_count;
  logic [23:0] lower_z, upper_z;
  logic        single;

  logic [AW-1:0]      i;
  logic               ridge;
  logic [15:0]        qmass;
  logic [23:0]        qz;
  logic [15:0]        m0, m1;
  logic signed [31:0] y0, y1;
  logic signed [17:0] tfrac;
  logic signed [34:0] lo, hi;
  logic               zden;
  log_sel_t           lsel;
  logic [23:0]        lx;
  logic [4:0]         le;
  logic [15:0]        lfrac;
  logic [3:0]         lk;
  logic [20:0]        lz, uz, cz;
  logic signed [62:0] mprod;
  logic signed [63:0] res;
  logic               ovalid;
  logic signed [31:0] oyield;
  logic [1:0]         ostatus;

  // table ports
  logic          in_acc, load_en;
  logic [AW-1:0] raddr;
  logic [47:0]   lo_rd, up_rd, rd;

  assign in_acc  = req.valid && req.ready;
  assign load_en = in_acc && !req.req_type && (32'(req.point_index) < POINTS_MAX);
  assign raddr   = (state == S_RD0) ? i : i + AW'(1);
  assign rd      = ridge ? up_rd : lo_rd;

  tryi_ram #(.WIDTH(48), .DEPTH(POINTS_MAX)) u_lower (
    .clk(clk), .we(load_en && !req.ridge_sel), .waddr(AW'(req.point_index)),
    .wdata({req.mass, req.yield_value}), .raddr(raddr), .rdata(lo_rd)
  );
  tryi_ram #(.WIDTH(48), .DEPTH(POINTS_MAX)) u_upper (
    .clk(clk), .we(load_en && req.ridge_sel), .waddr(AW'(req.point_index)),
    .wdata({req.mass, req.yield_value}), .raddr(raddr), .rdata(up_rd)
  );

  // effective point count of the active ridge
  logic [NW-1:0] cnt_ext, n_eff;
  logic          srch_more;
  always_comb begin
    cnt_ext = NW'(ridge ? upper_count : lower_count);
    if (cnt_ext < NW'(2)) n_eff = NW'(2);
    else if (cnt_ext > NW'(POINTS_MAX)) n_eff = NW'(POINTS_MAX);
    else n_eff = cnt_ext;
  end
  assign srch_more = (NW'(i) < n_eff - NW'(2)) && (rd[47:32] <= qmass);

  // shared divider
  logic                    div_start, div_done;
  logic signed [DIV_W-1:0] div_a, div_b, div_q;
  logic signed [16:0]      mdiff, mden;
  logic signed [21:0]      num, den;

  assign mdiff = $signed({1'b0, qmass}) - $signed({1'b0, m0});
  assign mden  = $signed({1'b0, m1}) - $signed({1'b0, m0});
  assign num   = $signed({1'b0, cz}) - $signed({1'b0, lz});
  assign den   = $signed({1'b0, uz}) - $signed({1'b0, lz});

  always_comb begin
    div_start = 1'b0;
    div_a     = 64'(mprod);
    div_b     = 64'(den);
    if (state == S_FRAC_DIV) begin
      div_start = (mden != 17'sd0);
      div_a     = 64'(mdiff) <<< 16;
      div_b     = 64'(mden);
    end else if (state == S_BL_DIV) begin
      div_start = 1'b1;
    end
  end

  tryi_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  // shared multiplier, operands chosen by step
  logic signed [36:0] ma;
  logic signed [25:0] mb;
  always_comb begin
    case (state)
      S_VMUL: begin
        ma = 37'(33'(y1) - 33'(y0));
        mb = 26'(tfrac);
      end
      S_LOG_SQ: begin
        ma = $signed({13'b0, lx});
        mb = $signed({2'b0, lx});
      end
      default: begin
        ma = 37'(hi) - 37'(lo);
        mb = 26'(num);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mprod <= ma * mb;
  end

  // ridge value arithmetic
  function automatic logic [1:0] sgn(input logic signed [34:0] x);
    return {x[34], x != 35'sd0};
  endfunction

  logic signed [62:0] vq;
  logic signed [34:0] y0e, y1e, vraw, vfix;
  logic signed [63:0] tq;
  assign vq   = (mprod + (mprod[62] ? 63'sd65535 : 63'sd0)) >>> 16;
  assign y0e  = 35'(y0);
  assign y1e  = 35'(y1);
  assign vraw = y0e + 35'(vq);
  assign vfix = (sgn(y0e) == sgn(y1e) && sgn(y0e) != sgn(vraw)) ? 35'sd0 : vraw;
  assign tq   = (div_q < FRAC_LO) ? FRAC_LO : ((div_q > FRAC_HI) ? FRAC_HI : div_q);

  // logarithm operand and squaring step
  logic [23:0] zl, zu, zq, lval;
  logic [25:0] lp;
  logic [15:0] lfrac_new;
  assign zl = (lower_z == 24'd0) ? 24'd1 : lower_z;
  assign zu = (upper_z == 24'd0) ? 24'd1 : upper_z;
  assign zq = (qz == 24'd0) ? 24'd1 : qz;
  always_comb begin
    case (lsel)
      LOG_LOWER: lval = zl;
      LOG_UPPER: lval = zu;
      default:   lval = (zq < zu) ? zq : zu;
    endcase
  end
  assign lp        = mprod[48:23];
  assign lfrac_new = {lfrac[14:0], lp[24]};

  // output saturation
  logic signed [31:0] sat_val;
  logic               sat;
  assign sat     = (res > INT32_MAX) || (res < INT32_MIN);
  assign sat_val = (res > INT32_MAX) ? 32'sh7FFFFFFF :
                   ((res < INT32_MIN) ? 32'sh80000000 : res[31:0]);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_acc && req.req_type) state_next = S_SRCH_RD;
      S_SRCH_RD:   state_next = S_SRCH_CK;
      S_SRCH_CK:   state_next = srch_more ? S_SRCH_RD : S_RD0;
      S_RD0:       state_next = S_RD0_CK;
      S_RD0_CK:    state_next = S_FRAC_DIV;
      S_FRAC_DIV:  state_next = (mden == 17'sd0) ? S_VMUL : S_FRAC_WAIT;
      S_FRAC_WAIT: if (div_done) state_next = S_VMUL;
      S_VMUL:      state_next = S_VFIX;
      S_VFIX: begin
        if (single) state_next = S_FINISH;
        else if (!ridge) state_next = S_SRCH_RD;
        else state_next = S_LOG_INIT;
      end
      S_LOG_INIT:  state_next = S_LOG_NORM;
      S_LOG_NORM:  if (lx[23]) state_next = S_LOG_SQ;
      S_LOG_SQ:    state_next = S_LOG_ADJ;
      S_LOG_ADJ: begin
        if (lk != 4'd15) state_next = S_LOG_SQ;
        else if (lsel == LOG_QUERY) state_next = S_BL_MUL;
        else state_next = S_LOG_INIT;
      end
      S_BL_MUL:    state_next = (den == 22'sd0) ? S_FINISH : S_BL_DIV;
      S_BL_DIV:    state_next = S_BL_WAIT;
      S_BL_WAIT:   if (div_done) state_next = S_FINISH;
      S_FINISH:    if (!ovalid || rsp.ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count <= 5'd2;
      upper_count <= 5'd2;
      lower_z     <= 24'd1677;
      upper_z     <= 24'd335544;
      single      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER_COUNT: lower_count <= cfg_data[4:0];
        CFG_UPPER_COUNT: upper_count <= cfg_data[4:0];
        CFG_LOWER_Z:     lower_z     <= cfg_data;
        CFG_UPPER_Z:     upper_z     <= cfg_data;
        CFG_SINGLE:      single      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        i     <= '0;
        ridge <= 1'b0;
        zden  <= 1'b0;
        lsel  <= LOG_LOWER;
        qmass <= req.mass;
        qz    <= req.metallicity;
      end
      S_SRCH_CK: begin
        m1 <= rd[47:32];
        y1 <= $signed(rd[31:0]);
        if (srch_more) i <= i + AW'(1);
      end
      S_RD0_CK: begin
        m0 <= rd[47:32];
        y0 <= $signed(rd[31:0]);
      end
      S_FRAC_DIV: begin
        if (mden == 17'sd0) begin
          zden  <= 1'b1;
          tfrac <= 18'sd0;
        end
      end
      S_FRAC_WAIT: if (div_done) tfrac <= 18'(tq);
      S_VFIX: begin
        if (!ridge) lo <= vfix;
        else hi <= vfix;
        res   <= 64'(vfix);
        ridge <= 1'b1;
        i     <= '0;
      end
      S_LOG_INIT: begin
        lx    <= lval;
        le    <= 5'd23;
        lfrac <= '0;
        lk    <= '0;
      end
      S_LOG_NORM: begin
        if (!lx[23]) begin
          lx <= {lx[22:0], 1'b0};
          le <= le - 5'd1;
        end
      end
      S_LOG_ADJ: begin
        lx    <= lp[24] ? lp[24:1] : lp[23:0];
        lfrac <= lfrac_new;
        lk    <= lk + 4'd1;
        if (lk == 4'd15) begin
          case (lsel)
            LOG_LOWER: begin
              lz   <= {le, lfrac_new};
              lsel <= LOG_UPPER;
            end
            LOG_UPPER: begin
              uz   <= {le, lfrac_new};
              lsel <= LOG_QUERY;
            end
            default: cz <= {le, lfrac_new};
          endcase
        end
      end
      S_BL_MUL: begin
        res <= 64'(lo);
        if (den == 22'sd0) zden <= 1'b1;
      end
      S_BL_WAIT: if (div_done) res <= 64'(lo) + div_q;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == S_FINISH && (!ovalid || rsp.ready)) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!ovalid || rsp.ready)) begin
      oyield  <= sat_val;
      ostatus <= zden ? ST_ZDEN : (sat ? ST_SAT : ST_OK);
    end
  end

  assign rsp.valid              = ovalid;
  assign rsp.interpolated_yield = oyield;
  assign rsp.status             = ostatus;

  `TRYI_ASSERT(a_div_done_waited, clk, rst, div_done |-> (state == S_FRAC_WAIT || state == S_BL_WAIT))
  `TRYI_ASSERT(a_query_starts, clk, rst, (in_acc && req.req_type) |=> (state == S_SRCH_RD))
  `TRYI_ASSERT(a_bracket_bound, clk, rst, (state == S_SRCH_CK) |-> (NW'(i) <= n_eff - NW'(2)))
  `TRYI_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (state == S_IDLE && !ovalid))

endmodule

/* tb/tb_two_ridge_yield_interpolator_top.sv */
`timescale 1ns / 1ps
module tb_two_ridge_yield_interpolator_top;
  import tryi_pkg::*;

  localparam int TBL_DEPTH = 16;
  localparam int SETTLE_CYCLES = 700;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam logic RIDGE_LOWER = 1'b0;
  localparam logic RIDGE_UPPER = 1'b1;

  typedef struct {
    logic               kind;
    logic               ridge;
    logic [3:0]         idx;
    logic [15:0]        mass;
    logic signed [31:0] yv;
    logic [23:0]        z;
  } txn_t;

  typedef struct {
    logic signed [31:0] yv;
    logic [1:0]         st;
  } yield_rsp_t;

  typedef struct {
    txn_t               t;
    bit                 typed;
    logic signed [31:0] yv;
    logic [1:0]         st;
  } dir_row_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  tryi_req_if req ();
  tryi_rsp_if rsp ();

  two_ridge_yield_interpolator_top u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [15:0]        mass_tbl[2][TBL_DEPTH];
  logic signed [31:0] yld_tbl[2][TBL_DEPTH];
  int unsigned        pt_count[2];
  int unsigned        z_lower, z_upper;
  bit                 single_mode;

  yield_rsp_t expected_yields[$];
  int errors = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  int hold_cycles = 0;
  bit typed_next = 0;
  yield_rsp_t typed_val;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int sgn(input longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic longint ridge_yield(input int r, input int unsigned mq, inout bit zd);
    int unsigned n;
    int unsigned i;
    longint den, t, y1, y2, v;
    n = pt_count[r] < 2 ? 2 : (pt_count[r] > TBL_DEPTH ? TBL_DEPTH : pt_count[r]);
    i = 0;
    while (i < n - 2 && mass_tbl[r][i+1] <= mq) i++;
    den = longint'(mass_tbl[r][i+1]) - longint'(mass_tbl[r][i]);
    if (den == 0) begin
      zd = 1;
      t = 0;
    end else begin
      t = ((longint'(mq) - longint'(mass_tbl[r][i])) * 65536) / den;
      if (t < FRAC_LO) t = FRAC_LO;
      if (t > FRAC_HI) t = FRAC_HI;
    end
    y1 = longint'(yld_tbl[r][i]);
    y2 = longint'(yld_tbl[r][i+1]);
    v = y1 + ((y2 - y1) * t) / 65536;
    // extrapolation may not flip a sign that both points share
    if (sgn(y1) == sgn(y2) && sgn(y1) != sgn(v)) v = 0;
    return v;
  endfunction

  function automatic longint log2_q16(input int unsigned v);
    int e;
    longint unsigned x;
    longint unsigned frac;
    v = v & 24'hFFFFFF;
    if (v == 0) v = 1;
    e = 23;
    while (((v >> e) & 1) == 0) e--;
    x = longint'(v) << (23 - e);
    frac = 0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 23;
      frac = frac << 1;
      if (x >= (64'd1 << 24)) begin
        frac = frac | 1;
        x = x >> 1;
      end
    end
    return longint'((longint'(e) << 16) | frac);
  endfunction

  function automatic yield_rsp_t blend_yield(input txn_t t);
    yield_rsp_t r;
    bit zd;
    bit sat;
    longint lo, hi, res, lz, uz, cz, num, den;
    int unsigned zl, zu, zq, zc;
    zd = 0;
    sat = 0;
    lo = ridge_yield(0, t.mass, zd);
    res = lo;
    if (!single_mode) begin
      zl = z_lower == 0 ? 1 : z_lower;
      zu = z_upper == 0 ? 1 : z_upper;
      zq = t.z == 0 ? 1 : t.z;
      zc = zq < zu ? zq : zu;
      hi = ridge_yield(1, t.mass, zd);
      lz = log2_q16(zl);
      uz = log2_q16(zu);
      cz = log2_q16(zc);
      num = cz - lz;
      den = uz - lz;
      if (den == 0) zd = 1;
      else res = lo + ((hi - lo) * num) / den;
    end
    if (res > INT32_MAX) begin
      res = INT32_MAX;
      sat = 1;
    end
    if (res < INT32_MIN) begin
      res = INT32_MIN;
      sat = 1;
    end
    r.yv = res[31:0];
    r.st = zd ? ST_ZDEN : (sat ? ST_SAT : ST_OK);
    return r;
  endfunction

  // accepted transactions update the tables or queue a prediction
  always @(posedge clk) begin
    txn_t t;
    if (!rst && req.valid && req.ready) begin
      t.kind = req.req_type;
      t.ridge = req.ridge_sel;
      t.idx = req.point_index;
      t.mass = req.mass;
      t.yv = req.yield_value;
      t.z = req.metallicity;
      if (t.kind == REQ_LOAD) begin
        mass_tbl[t.ridge][t.idx] = t.mass;
        yld_tbl[t.ridge][t.idx] = t.yv;
      end else if (typed_next) begin
        expected_yields.push_back(typed_val);
      end else begin
        expected_yields.push_back(blend_yield(t));
      end
    end
  end

  always @(posedge clk) begin
    yield_rsp_t w;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_yields.size() == 0) begin
        report_mismatch("unexpected result", rsp.interpolated_yield, 0);
      end else begin
        w = expected_yields.pop_front();
        if (rsp.interpolated_yield !== w.yv)
          report_mismatch("interpolated_yield", rsp.interpolated_yield, w.yv);
        if (rsp.status !== w.st) report_mismatch("status", rsp.status, w.st);
      end
    end
  end

  // receiver side, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      rsp.ready <= ($urandom_range(99) >= 65);
    end else if (idle_mode == IDLE_BOTH) begin
      rsp.ready <= ($urandom_range(99) >= 29);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  task automatic write_reg(input cfg_index_t ix, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_data <= val;
    case (ix)
      CFG_LOWER_COUNT: pt_count[0] = val[4:0];
      CFG_UPPER_COUNT: pt_count[1] = val[4:0];
      CFG_LOWER_Z: z_lower = val;
      CFG_UPPER_Z: z_upper = val;
      CFG_SINGLE: single_mode = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_txn(input txn_t t);
    int gap_pct;
    gap_pct = idle_mode == IDLE_SEND ? 65 : (idle_mode == IDLE_BOTH ? 29 : 0);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    req.valid <= 1'b1;
    req.req_type <= t.kind;
    req.ridge_sel <= t.ridge;
    req.point_index <= t.idx;
    req.mass <= t.mass;
    req.yield_value <= t.yv;
    req.metallicity <= t.z;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    req.valid <= 1'b0;
    typed_next <= 1'b0;
    @(posedge clk);
    while (expected_yields.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_yield();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(32'h03FFFFFF));
      3: return -$signed($urandom_range(32'h03FFFFFF));
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic txn_t rand_txn();
    txn_t t;
    t.ridge = $urandom_range(1);
    t.idx = $urandom_range(15);
    t.yv = rand_yield();
    t.z = $urandom_range(9) == 0 ? 24'd0 : 24'($urandom());
    if ($urandom_range(99) < 30) begin
      t.kind = REQ_LOAD;
      // mostly keep masses ascending so brackets are meaningful
      t.mass = $urandom_range(99) < 75 ? 16'(t.idx * 4096 + $urandom_range(4095))
                                       : 16'($urandom());
    end else begin
      t.kind = REQ_QUERY;
      t.mass = 16'($urandom());
    end
    return t;
  endfunction

  function automatic txn_t mk(input logic k, input logic r, input logic [3:0] i,
                              input logic [15:0] m, input logic signed [31:0] y,
                              input logic [23:0] z);
    txn_t t;
    t.kind = k; t.ridge = r; t.idx = i; t.mass = m; t.yv = y; t.z = z;
    return t;
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    txn_t t;
    int unsigned lc[7] = '{16, 2, 31, 7, 16, 9, 3};
    int unsigned uc[7] = '{16, 2, 0, 12, 5, 16, 16};
    int unsigned zl[7] = '{1677, 1, 24'hFFFFFF, 0, 1677, 100000, 1677};
    int unsigned zu[7] = '{335544, 24'hFFFFFF, 24'hFFFFFF, 1000, 335544, 50, 335544};
    bit sg[7] = '{0, 0, 0, 0, 1, 0, 0};
    req.valid <= 1'b0;
    req.req_type <= REQ_LOAD;
    req.ridge_sel <= RIDGE_LOWER;
    req.point_index <= '0;
    req.mass <= '0;
    req.yield_value <= '0;
    req.metallicity <= 24'd1;
    pt_count = '{2, 2};
    z_lower = 1677;
    z_upper = 335544;
    single_mode = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every table entry gets written before any count can reach it
    for (int r = 0; r < 2; r++)
      for (int i = 0; i < TBL_DEPTH; i++)
        send_txn(mk(REQ_LOAD, r[0], 4'(i), 16'(i * 4096 + $urandom_range(4095)),
                    rand_yield(), 24'd1));
    drain_and_settle();

    write_reg(CFG_SINGLE, 24'd1);
    write_reg(CFG_LOWER_COUNT, 24'd2);
    dir_rows = '{
      '{mk(REQ_LOAD, RIDGE_LOWER, 0, 16'h0100, 32'sh01000000, 1), 0, 0, ST_OK},
      '{mk(REQ_LOAD, RIDGE_LOWER, 1, 16'h0200, 32'sh02000000, 1), 0, 0, ST_OK},
      '{mk(REQ_QUERY, RIDGE_LOWER, 0, 16'h0180, 0, 24'hFFFFFF), 1, 32'sh01800000, ST_OK},
      '{mk(REQ_QUERY, RIDGE_UPPER, 15, 16'h0100, 0, 1), 1, 32'sh01000000, ST_OK},
      '{mk(REQ_QUERY, RIDGE_LOWER, 0, 16'h0000, 0, 0), 0, 0, ST_OK},
      '{mk(REQ_QUERY, RIDGE_LOWER, 0, 16'hFFFF, -1, 1), 0, 0, ST_OK},
      // equal bracket masses
      '{mk(REQ_LOAD, RIDGE_LOWER, 1, 16'h0100, 32'sh7FFFFFFF, 1), 0, 0, ST_OK},
      '{mk(REQ_QUERY, RIDGE_LOWER, 0, 16'h0150, 0, 1), 1, 32'sh01000000, ST_ZDEN},
      // sign flip from extrapolation forces zero
      '{mk(REQ_LOAD, RIDGE_LOWER, 1, 16'h0200, 32'sh00100000, 1), 0, 0, ST_OK},
      '{mk(REQ_QUERY, RIDGE_LOWER, 0, 16'hFFFF, 0, 1), 1, 32'sh00000000, ST_OK},
      // extreme yields saturate low
      '{mk(REQ_LOAD, RIDGE_LOWER, 0, 16'h0100, 32'sh80000000, 1), 0, 0, ST_OK},
      '{mk(REQ_LOAD, RIDGE_LOWER, 1, 16'h0200, 32'sh7FFFFFFF, 1), 0, 0, ST_OK},
      '{mk(REQ_QUERY, RIDGE_LOWER, 0, 16'h0000, 0, 1), 1, 32'sh80000000, ST_SAT},
      '{mk(REQ_QUERY, RIDGE_LOWER, 0, 16'hFFFF, 0, 1), 0, 0, ST_OK},
      '{mk(REQ_LOAD, RIDGE_UPPER, 15, 16'hFFFF, 32'sh7FFFFFFF, 1), 0, 0, ST_OK},
      '{mk(REQ_LOAD, RIDGE_UPPER, 14, 16'hF000, 32'sh80000000, 1), 0, 0, ST_OK}
    };
    foreach (dir_rows[k]) begin
      // updated after the monitor has seen the previous transaction
      typed_next <= dir_rows[k].typed;
      typed_val.yv <= dir_rows[k].yv;
      typed_val.st <= dir_rows[k].st;
      send_txn(dir_rows[k].t);
    end
    drain_and_settle();

    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_LOWER_COUNT, 24'(lc[p]));
      write_reg(CFG_UPPER_COUNT, 24'(uc[p]));
      write_reg(CFG_LOWER_Z, 24'(zl[p]));
      write_reg(CFG_UPPER_Z, 24'(zu[p]));
      write_reg(CFG_SINGLE, 24'(sg[p]));
      idle_mode = idle_mode_t'(p % 4);
      if (p == 6) hold_cycles = 3000;
      for (int n = 0; n < 110; n++) begin
        t = rand_txn();
        send_txn(t);
      end
      drain_and_settle();
    end

    if (errors == 0) begin
      $display("tb_two_ridge_yield_interpolator_top: clean");
    end else begin
      $display("tb_two_ridge_yield_interpolator_top: errors");
    end
    $finish;
  end

  initial begin
    #(12.0 * 4000000);
    $display("tb_two_ridge_yield_interpolator_top: errors");
    $finish;
  end

endmodule
